[rtl/skr_pkg.sv]
// ============================================================================
// skr_pkg: shared types and constants for the keyed-remove stack
// Item and result structs, command codes, result status codes, back-end states.
// ============================================================================
`default_nettype none

package skr_pkg;

    localparam int DEPTH_DEFAULT = 4;
    localparam int KEY_W         = 56;
    localparam int TAG_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int POS_W         = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ASIDE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  plate;
        logic [TAG_W-1:0]  apartment;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    plate_res;
        logic [TAG_W-1:0]    apartment_res;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    count_above;
        logic                last;
    } out_t;

    typedef enum logic {
        OP_PUSH   = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } rec_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SEARCH,
        BS_ASIDE,
        BS_SHIFT
    } back_state_t;

endpackage

`default_nettype wire

[rtl/skr_front.sv]
// ============================================================================
// skr_front: command intake
// Accepts items, decodes them into push/remove commands and holds them in a
// two-entry queue for the back end.
// ============================================================================
`default_nettype none

module skr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire skr_pkg::in_t   item,
    output logic                busy,
    output skr_pkg::q_head_t    head,
    input  wire logic           pop
);
    import skr_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    cmd_t       cmd;

    assign busy   = (count_reg == 2'd2);
    assign accept = start && !busy;

    always_comb
    begin
        cmd.op  = item.kind ? OP_REMOVE : OP_PUSH;
        cmd.key = item.plate;
        // the tag only matters for a push
        cmd.tag = item.kind ? '0 : item.apartment;
    end

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, accept} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/skr_back.sv]
// ============================================================================
// skr_back: stack engine
// Holds the records in a one-port-read, one-port-write memory, runs push,
// top-down search, moved-aside reporting and compaction one slot per cycle.
// ============================================================================
`default_nettype none

module skr_back #(
    parameter int DEPTH = skr_pkg::DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire skr_pkg::q_head_t head,
    output logic                  pop,
    output logic                  result_valid,
    output skr_pkg::out_t         result
);
    import skr_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CW1 = CW + 1;

    rec_t            mem [DEPTH];
    rec_t            rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            we;
    logic [AW-1:0]   wr_addr;
    rec_t            wr_data;

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;
    logic [AW-1:0]   slot_reg;
    logic [AW-1:0]   slot_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    out_t            res_reg;
    out_t            res_next;
    logic            res_valid_reg;
    logic            res_valid_next;

    logic            hit;
    logic            full;
    logic            empty;
    logic [AW-1:0]   top_idx;
    logic [CW-1:0]   above;
    logic            aside_last;
    logic            shift_done;

    assign hit        = (rd_data_reg.key == key_reg);
    assign full       = (cnt_reg == CW'(DEPTH));
    assign empty      = (cnt_reg == '0);
    assign top_idx    = AW'(cnt_reg - 1'b1);
    assign above      = CW'(cnt_reg - 1'b1 - CW'(idx_reg));
    assign aside_last = (idx_reg == AW'(slot_reg + 1'b1));
    assign shift_done = ((CW1'(idx_reg) + CW1'(2)) == CW1'(cnt_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid && head.cmd.op == OP_REMOVE && !empty)
                begin
                    state_next = BS_SEARCH;
                end
            end
            BS_SEARCH:
            begin
                if (hit)
                begin
                    state_next = (above == '0) ? BS_IDLE : BS_ASIDE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_ASIDE:
            begin
                if (aside_last)
                begin
                    state_next = BS_SHIFT;
                end
            end
            BS_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop            = 1'b0;
        rd_addr        = idx_reg;
        we             = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    pop            = 1'b1;
                    key_next       = head.cmd.key;
                    res_valid_next = 1'b1;
                    res_next.plate_res     = head.cmd.key;
                    res_next.apartment_res = head.cmd.tag;
                    res_next.position      = '0;
                    res_next.count_above   = '0;
                    res_next.last          = 1'b1;
                    if (head.cmd.op == OP_PUSH)
                    begin
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            we                = 1'b1;
                            wr_addr           = AW'(cnt_reg);
                            wr_data.key       = head.cmd.key;
                            wr_data.tag       = head.cmd.tag;
                            res_next.status   = ST_STORED;
                            res_next.position = POS_W'(cnt_reg);
                            cnt_next          = cnt_reg + 1'b1;
                        end
                    end
                    else if (empty)
                    begin
                        res_next.status        = ST_MISS;
                        res_next.apartment_res = '0;
                    end
                    else
                    begin
                        // search starts at the top; nothing reported yet
                        res_valid_next = 1'b0;
                        idx_next       = top_idx;
                        rd_addr        = top_idx;
                    end
                end
            end
            BS_SEARCH:
            begin
                if (hit)
                begin
                    res_valid_next         = 1'b1;
                    res_next.status        = ST_FOUND;
                    res_next.plate_res     = rd_data_reg.key;
                    res_next.apartment_res = rd_data_reg.tag;
                    res_next.position      = POS_W'(idx_reg);
                    res_next.count_above   = POS_W'(above);
                    res_next.last          = (above == '0);
                    slot_next              = idx_reg;
                    if (above == '0)
                    begin
                        // match on top: nothing to compact
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        idx_next = top_idx;
                        rd_addr  = top_idx;
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_valid_next         = 1'b1;
                    res_next.status        = ST_MISS;
                    res_next.plate_res     = key_reg;
                    res_next.apartment_res = '0;
                    res_next.position      = '0;
                    res_next.count_above   = '0;
                    res_next.last          = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    rd_addr  = idx_reg - 1'b1;
                end
            end
            BS_ASIDE:
            begin
                res_valid_next         = 1'b1;
                res_next.status        = ST_ASIDE;
                res_next.plate_res     = rd_data_reg.key;
                res_next.apartment_res = rd_data_reg.tag;
                res_next.position      = POS_W'(idx_reg);
                res_next.count_above   = '0;
                res_next.last          = aside_last;
                if (aside_last)
                begin
                    // compaction: read slot+1, write slot
                    idx_next = slot_reg;
                    rd_addr  = idx_reg;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    rd_addr  = idx_reg - 1'b1;
                end
            end
            BS_SHIFT:
            begin
                // rd_data_reg holds the record of slot idx+1
                we      = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (shift_done)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = AW'(CW1'(idx_reg) + CW1'(2));
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

[rtl/stack_keyed_remove_top.sv]
// ============================================================================
// stack_keyed_remove_top: bounded record stack with search-and-remove by key
// Intake queue in front of a memory-based stack engine.
// ============================================================================
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Results come out one per cycle on
// result, marked by result_valid for a single cycle, and cannot be held off;
// last flags the final beat of an item. A remove whose match lies H slots
// below the top searches the stored records from the top down, gives the
// found beat and then H moved-aside beats, and compacts the H records above
// the match; a miss searches every stored record and gives one beat. The
// single read port of the record memory visits one slot per cycle in the
// search, report and compaction passes.
// ============================================================================
`default_nettype none

module stack_keyed_remove_top #(
    parameter int DEPTH = skr_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire skr_pkg::in_t  item,
    output logic               busy,
    output logic               result_valid,
    output skr_pkg::out_t      result
);
    import skr_pkg::*;

    q_head_t head;
    logic    pop;

    skr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    skr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // single-beat outcomes always close their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_STORED || result.status == ST_FULL ||
                         result.status == ST_MISS)
        |-> result.last)
        else $error("single-beat result without last");

    // a moved-aside beat follows an open found or moved-aside beat
    a_aside_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_ASIDE
        |-> $past(result_valid) && !$past(result.last) &&
            ($past(result.status) == ST_FOUND || $past(result.status) == ST_ASIDE))
        else $error("moved-aside beat out of sequence");

    // after a non-last beat, the next beat is a moved-aside record
    a_open_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last
        |=> result_valid && result.status == ST_ASIDE)
        else $error("open item not continued");

    // moved-aside records never carry a count
    a_aside_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_ASIDE |-> result.count_above == '0)
        else $error("moved-aside beat with nonzero count");

endmodule

`default_nettype wire

[dv/skr_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// skr_checker: result checker for the keyed-remove stack
// Watches the command and result channels and keeps its own copy of the stack.
// For each accepted command it queues the expected result beats, then compares
// every result beat, field by field, with the oldest queued beat.
// ============================================================================

module skr_checker #(
    parameter int DEPTH = skr_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  skr_pkg::in_t   item,
    input  logic           result_valid,
    input  skr_pkg::out_t  result,
    output int             errors,
    output int             pending
);

    import skr_pkg::*;

    logic [KEY_W-1:0] shadow_key [DEPTH];
    logic [TAG_W-1:0] shadow_tag [DEPTH];
    int               shadow_fill;
    out_t             expected_beats [$];

    function automatic out_t make_beat(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                       logic [TAG_W-1:0] tag, int pos, int above, bit fin);
        out_t r;
        r.status        = status;
        r.plate_res     = key;
        r.apartment_res = tag;
        r.position      = POS_W'(pos);
        r.count_above   = POS_W'(above);
        r.last          = fin;
        return r;
    endfunction

    // updates the shadow stack and queues the beats one command produces
    function automatic void predict_stack_op(in_t x);
        int slot;
        int j;
        int above;
        bit hit;
        slot = 0;
        hit  = 1'b0;
        if (op_t'(x.kind) == OP_PUSH) begin
            if (shadow_fill < DEPTH) begin
                shadow_key[shadow_fill] = x.plate;
                shadow_tag[shadow_fill] = x.apartment;
                expected_beats.push_back(make_beat(ST_STORED, x.plate, x.apartment,
                                                   shadow_fill, 0, 1'b1));
                shadow_fill++;
            end
            else
            begin
                expected_beats.push_back(make_beat(ST_FULL, x.plate, x.apartment, 0, 0, 1'b1));
            end
            return;
        end
        // search from the top down, first match wins
        for (j = shadow_fill - 1; j >= 0; j--) begin
            if (!hit && shadow_key[j] == x.plate) begin
                slot = j;
                hit  = 1'b1;
            end
        end
        if (!hit) begin
            expected_beats.push_back(make_beat(ST_MISS, x.plate, '0, 0, 0, 1'b1));
            return;
        end
        above = shadow_fill - 1 - slot;
        expected_beats.push_back(make_beat(ST_FOUND, shadow_key[slot], shadow_tag[slot],
                                           slot, above, above == 0));
        for (j = shadow_fill - 1; j > slot; j--)
            expected_beats.push_back(make_beat(ST_ASIDE, shadow_key[j], shadow_tag[j],
                                               j, 0, j == slot + 1));
        for (j = slot; j + 1 < shadow_fill; j++) begin
            shadow_key[j] = shadow_key[j + 1];
            shadow_tag[j] = shadow_tag[j + 1];
        end
        shadow_fill--;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
        errors++;
    endtask

    task automatic check_result_beat(out_t got);
        out_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", '0, 64'(got.plate_res));
            return;
        end
        want = expected_beats.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.plate_res !== want.plate_res)
            report_mismatch("plate_res", 64'(want.plate_res), 64'(got.plate_res));
        if (got.apartment_res !== want.apartment_res)
            report_mismatch("apartment_res", 64'(want.apartment_res), 64'(got.apartment_res));
        if (got.position !== want.position)
            report_mismatch("position", 64'(want.position), 64'(got.position));
        if (got.count_above !== want.count_above)
            report_mismatch("count_above", 64'(want.count_above), 64'(got.count_above));
        if (got.last !== want.last)
            report_mismatch("last", 64'(want.last), 64'(got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shadow_fill = 0;
            expected_beats.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // the new command's beats go behind anything older
            if (start && !busy)
                predict_stack_op(item);
            if (result_valid)
                check_result_beat(result);
            pending = expected_beats.size();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the keyed-remove stack
// Drives push and remove commands, first a directed run over empty, full,
// duplicate-key, top, middle and bottom matches and misses, then random
// commands over a small key pool with random gaps. Checking is in skr_checker.
// ============================================================================

module tb_top;

    import skr_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int NUM_RANDOM   = 460;
    localparam int CALM_TAIL    = 80;
    localparam int POOL_SIZE    = 6;
    localparam int DRAIN_CYCLES = 3 * DEPTH + 20;
    localparam int LIMIT_CYCLES = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic result_valid;
    in_t  item;
    out_t result;
    int   errors;
    int   pending;
    int   cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    stack_keyed_remove_top #(.DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    skr_checker #(.DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    function automatic in_t make_cmd(op_t op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        in_t r;
        r.kind      = op;
        r.plate     = key;
        r.apartment = tag;
        return r;
    endfunction

    // presents one command and holds it until the block takes the beat
    task automatic send_cmd(in_t x);
        @(negedge clk);
        start <= 1'b1;
        item  <= x;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic in_t random_cmd();
        op_t              op;
        logic [KEY_W-1:0] key;
        op  = ($urandom_range(0, 99) < 55) ? OP_PUSH : OP_REMOVE;
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : random_key();
        return make_cmd(op, key, TAG_W'($urandom()));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = random_key();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty, fill, full, duplicate keys, top/bottom/middle matches
        send_cmd(make_cmd(OP_REMOVE, key_pool[0], 16'hFFFF));
        send_cmd(make_cmd(OP_PUSH, key_pool[0], 16'h0000));
        send_cmd(make_cmd(OP_PUSH, key_pool[1], 16'hFFFF));
        send_cmd(make_cmd(OP_PUSH, key_pool[2], TAG_W'($urandom())));
        send_cmd(make_cmd(OP_PUSH, key_pool[0], 16'h1234));
        send_cmd(make_cmd(OP_PUSH, key_pool[3], 16'hA5A5));
        send_cmd(make_cmd(OP_REMOVE, key_pool[0], 16'hFFFF));
        send_cmd(make_cmd(OP_PUSH, key_pool[2], 16'h5A5A));
        send_cmd(make_cmd(OP_REMOVE, key_pool[0], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[3], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[2], '1));
        send_cmd(make_cmd(OP_REMOVE, key_pool[1], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[2], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[2], '0));
        for (int i = 2; i < POOL_SIZE; i++)
            send_cmd(make_cmd(OP_PUSH, key_pool[i], TAG_W'($urandom())));
        send_cmd(make_cmd(OP_REMOVE, key_pool[3], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[2], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[5], '0));
        send_cmd(make_cmd(OP_REMOVE, key_pool[4], '0));
        send_cmd(make_cmd(OP_REMOVE, random_key(), '1));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 18));
            send_cmd(random_cmd());
        end
        @(negedge clk);
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
